FILE: design/fcae_pkg.sv
// ----------------------------------------------------------------------------
// fcae_pkg
// Shared types and constants of the four-sequence autocorrelation energy core.
// ----------------------------------------------------------------------------
package fcae_pkg;

  // default sequence store depth per sequence
  localparam int MaxLenDef = 256;

  // correlation word width
  localparam int CorrW = 12;

  // configuration port
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 9;
  localparam logic [CfgIdxW-1:0]  CfgLenFirst  = 1'b0;
  localparam logic [CfgIdxW-1:0]  CfgLenSecond = 1'b1;
  localparam logic [CfgDataW-1:0] LenFirstRst  = 9'd32;
  localparam logic [CfgDataW-1:0] LenSecondRst = 9'd31;

  // energy limits
  localparam logic [28:0] EnergyCap = 29'h1000_0000;

  // item kinds
  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_CALC = 2'd1,
    KIND_FLIP = 2'd2
  } kind_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLR,
    ST_RC_RUN,
    ST_RC_TAIL,
    ST_PREP,
    ST_ROT,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] which_sequence;
    logic [7:0] position;
    logic       element_value;
  } in_word_t;

  typedef struct packed {
    logic [28:0]        energy;
    logic signed [29:0] energy_change;
    logic               all_zero;
  } out_word_t;

  // per-cell control
  typedef struct packed {
    logic clr;   // zero the correlation
    logic acc;   // accumulate stream products
    logic rot;   // take the neighbor's correlation
  } cell_ctl_t;

endpackage

FILE: design/fcae_ram.sv
// ----------------------------------------------------------------------------
// fcae_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module fcae_ram #(
  parameter int Width = 1,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  output logic [Width-1:0]         rdata_a_o,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

FILE: design/fcae_cell.sv
// ----------------------------------------------------------------------------
// fcae_cell
// One shift of the correlation chain: holds the correlation of its shift and
// one tap of the element delay line.
// ----------------------------------------------------------------------------
module fcae_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  fcae_pkg::cell_ctl_t        ctl_i,
  input  logic                       x_i,       // current stream element
  input  logic                       sv_i,      // stream element valid
  input  logic                       acc_ok_i,  // cell takes part in accumulation
  input  logic                       tap_i,     // element shift positions back
  input  logic                       vin_i,     // tap valid
  input  logic [fcae_pkg::CorrW-1:0] corr_i,    // neighbor correlation
  output logic                       tap_o,
  output logic                       vld_o,
  output logic [fcae_pkg::CorrW-1:0] corr_o
);
  import fcae_pkg::*;

  logic             tap_q;
  logic             vld_q;
  logic [CorrW-1:0] corr_q, corr_d;

  // delay line tap
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vin_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tap_q <= tap_i;
  end

  // correlation update
  always_comb begin
    corr_d = corr_q;
    if (ctl_i.clr) begin
      corr_d = '0;
    end else if (ctl_i.rot) begin
      corr_d = corr_i;
    end else if (ctl_i.acc && acc_ok_i && sv_i && vin_i) begin
      corr_d = (x_i == tap_i) ? corr_q + CorrW'(1) : corr_q - CorrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corr_q <= '0;
    end else begin
      corr_q <= corr_d;
    end
  end

  assign tap_o  = tap_q;
  assign vld_o  = vld_q;
  assign corr_o = corr_q;

endmodule

FILE: design/four_sequence_autocorr_energy_core.sv
// ----------------------------------------------------------------------------
// four_sequence_autocorr_energy_core
// Aperiodic autocorrelation energy of four +1/-1 sequences with recompute and
// incremental single-element flips.
// ----------------------------------------------------------------------------
// A recompute streams the elements of all four sequences one per cycle through
// the cell chain, then rotates the chain once to sum the squares. A flip rotates
// the chain once, reading the two partner elements of each shift from the
// dual-read sequence store. One item is in work at a time; a finished result
// sits in the output register while the next item is taken. Correlations
// reset to zero; the sequence store is undefined until loaded.
module four_sequence_autocorr_energy_core #(
  parameter int MaxLen = fcae_pkg::MaxLenDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  fcae_pkg::in_word_t            in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output fcae_pkg::out_word_t           out_word_o,
  input  logic                          cfg_we_i,
  input  logic [fcae_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fcae_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import fcae_pkg::*;

  localparam int SW  = $clog2(MaxLen);
  localparam int LW  = $clog2(MaxLen + 1);
  localparam int AW  = $clog2(4 * MaxLen);
  localparam int IW  = ((SW > 8) ? SW : 8) + 1;
  localparam int CW  = (LW > CfgDataW) ? LW : CfgDataW;
  localparam logic [LW-1:0] LenMax = LW'(MaxLen);

  function automatic logic [AW-1:0] seq_addr(input logic [1:0] sel,
                                             input logic [SW-1:0] idx);
    return AW'(sel) * AW'(MaxLen) + AW'(idx);
  endfunction

  // configuration
  logic [CfgDataW-1:0] len_a_q, len_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_a_q <= LenFirstRst;
      len_b_q <= LenSecondRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgLenFirst:  len_a_q <= cfg_wdata_i;
        CfgLenSecond: len_b_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // effective lengths and window
  logic [LW-1:0] la, lb, win, lsel, ljw;
  assign la  = (CW'(len_a_q) > CW'(MaxLen)) ? LenMax : LW'(len_a_q);
  assign lb  = (CW'(len_b_q) > CW'(MaxLen)) ? LenMax : LW'(len_b_q);
  assign win = (la > lb) ? la : lb;

  // state and item registers
  state_e        state_q, state_d;
  logic [1:0]    kind_q, which_q;
  logic [7:0]    pos_q;
  logic [LW-1:0] cnt_q, cnt_d;
  logic [1:0]    j_q, j_d;
  logic          xp_q;
  logic          flip_act_q, flip_act_d;
  logic          ok_a_q, ok_a_d, ok_b_q, ok_b_d;
  logic          rd_vld_q, rd_vld_d, rd_first_q, rd_first_d;
  logic signed [32:0] acc_q, acc_d;
  logic          zero_q, zero_d;
  logic [28:0]   energy_q;
  logic          out_valid_q;
  out_word_t     out_q;

  logic in_fire, fin_fire, is_flip;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_flip    = (kind_q == KIND_FLIP);
  assign fin_fire   = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  // position arithmetic
  logic [IW-1:0] pos_w, in_pos_w, pos_plus, pos_minus;
  logic          pos_in_store, in_pos_in_store;
  assign pos_w           = IW'(pos_q);
  assign in_pos_w        = IW'(in_word_i.position);
  assign pos_plus        = pos_w + IW'(cnt_q);
  assign pos_minus       = pos_w - IW'(cnt_q);
  assign pos_in_store    = pos_w < IW'(MaxLen);
  assign in_pos_in_store = in_pos_w < IW'(MaxLen);
  assign lsel            = (which_q < 2'd2) ? la : lb;
  assign ljw             = (j_q < 2'd2) ? la : lb;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          priority if (in_word_i.kind == KIND_CALC) state_d = ST_CLR;
          else if (in_word_i.kind == KIND_FLIP)    state_d = ST_PREP;
          else                                     state_d = ST_IDLE;
        end
      end
      ST_CLR:     state_d = ST_RC_RUN;
      ST_RC_RUN:  if (cnt_q >= ljw && j_q == 2'd3) state_d = ST_RC_TAIL;
      ST_RC_TAIL: state_d = ST_ROT;
      ST_PREP:    state_d = ST_ROT;
      ST_ROT:     if (cnt_q == LenMax) state_d = ST_FIN;
      ST_FIN:     if (fin_fire) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // store ports
  logic          ram_we, ram_wdata, rdata_a, rdata_b;
  logic [AW-1:0] ram_waddr, raddr_a, raddr_b;
  cell_ctl_t     ctl;

  // head of the chain: one shift per cycle during rotation
  logic [CorrW-1:0]   head, head_new;
  logic signed [2:0]  pa, pb, psum;
  logic signed [3:0]  psum4, dc;
  logic [CorrW:0]     sum13;
  logic signed [CorrW-1:0] nc_s, oc_s;
  logic signed [23:0] sq_new, sq_old;
  logic signed [24:0] term;
  logic [LW-1:0]      s_proc;
  logic               in_win;

  assign s_proc = cnt_q - LW'(1);
  assign in_win = (state_q == ST_ROT) && (cnt_q >= LW'(2)) && (s_proc < win);
  assign pa     = !ok_a_q ? 3'sd0 : ((xp_q == rdata_a) ? 3'sd1 : -3'sd1);
  assign pb     = !ok_b_q ? 3'sd0 : ((xp_q == rdata_b) ? 3'sd1 : -3'sd1);
  assign psum   = pa + pb;
  assign psum4  = {psum[2], psum};
  assign dc     = 4'sd0 - (psum4 <<< 1);
  assign sum13  = {head[CorrW-1], head} + {{(CorrW-3){dc[3]}}, dc};
  assign head_new = (sum13[CorrW] != sum13[CorrW-1]) ?
                    (sum13[CorrW] ? {1'b1, {(CorrW-1){1'b0}}} : {1'b0, {(CorrW-1){1'b1}}}) :
                    sum13[CorrW-1:0];
  assign nc_s   = head_new;
  assign oc_s   = head;
  assign sq_new = nc_s * nc_s;
  assign sq_old = is_flip ? oc_s * oc_s : 24'sd0;
  assign term   = {sq_new[23], sq_new} - {sq_old[23], sq_old};

  // control and datapath next values
  always_comb begin
    cnt_d      = cnt_q;
    j_d        = j_q;
    flip_act_d = flip_act_q;
    ok_a_d     = 1'b0;
    ok_b_d     = 1'b0;
    rd_vld_d   = 1'b0;
    rd_first_d = 1'b0;
    acc_d      = acc_q;
    zero_d     = zero_q;
    ram_we     = 1'b0;
    ram_waddr  = seq_addr(which_q, pos_w[SW-1:0]);
    ram_wdata  = ~xp_q;
    raddr_a    = seq_addr(which_q, pos_w[SW-1:0]);
    raddr_b    = seq_addr(which_q, pos_minus[SW-1:0]);
    ctl        = '0;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        j_d   = '0;
        if (in_fire && in_word_i.kind == KIND_LOAD && in_pos_in_store) begin
          ram_we    = 1'b1;
          ram_waddr = seq_addr(in_word_i.which_sequence, in_pos_w[SW-1:0]);
          ram_wdata = in_word_i.element_value;
        end
      end
      ST_CLR: begin
        ctl.clr = 1'b1;
        acc_d   = '0;
        zero_d  = 1'b1;
      end
      ST_RC_RUN: begin
        ctl.acc = 1'b1;
        raddr_a = seq_addr(j_q, cnt_q[SW-1:0]);
        if (cnt_q < ljw) begin
          rd_vld_d   = 1'b1;
          rd_first_d = (cnt_q == '0);
          cnt_d      = cnt_q + LW'(1);
        end else begin
          cnt_d = '0;
          j_d   = j_q + 2'd1;
        end
      end
      ST_RC_TAIL: begin
        ctl.acc = 1'b1;
        cnt_d   = '0;
      end
      ST_PREP: begin
        acc_d      = '0;
        zero_d     = 1'b1;
        flip_act_d = is_flip && pos_in_store && (IW'(pos_q) < IW'(lsel));
      end
      ST_ROT: begin
        raddr_a = seq_addr(which_q, pos_plus[SW-1:0]);
        ok_a_d  = flip_act_q && (pos_plus < IW'(lsel));
        ok_b_d  = flip_act_q && (pos_w >= IW'(cnt_q));
        ctl.rot = (cnt_q != '0);
        if (in_win) begin
          acc_d = acc_q + {{8{term[24]}}, term};
          if (head_new != '0) zero_d = 1'b0;
        end
        cnt_d = cnt_q + LW'(1);
      end
      ST_FIN: begin
        if (fin_fire && is_flip && pos_in_store) begin
          ram_we = 1'b1;
        end
        flip_act_d = 1'b0;
      end
      default: ;
    endcase
  end

  // final energy
  logic signed [34:0] e_sum;
  logic [28:0]        e_new;
  out_word_t          res;
  assign e_sum = (is_flip ? {6'd0, energy_q} : 35'sd0) + {{2{acc_q[32]}}, acc_q};
  assign e_new = e_sum[34] ? 29'd0 :
                 (e_sum > {6'd0, EnergyCap}) ? EnergyCap : e_sum[28:0];
  always_comb begin
    res.energy        = e_new;
    res.energy_change = is_flip ? ($signed({1'b0, e_new}) - $signed({1'b0, energy_q}))
                                : 30'sd0;
    res.all_zero      = zero_q;
  end

  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      j_q         <= '0;
      flip_act_q  <= 1'b0;
      ok_a_q      <= 1'b0;
      ok_b_q      <= 1'b0;
      rd_vld_q    <= 1'b0;
      rd_first_q  <= 1'b0;
      acc_q       <= '0;
      zero_q      <= 1'b1;
      energy_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      j_q        <= j_d;
      flip_act_q <= flip_act_d;
      ok_a_q     <= ok_a_d;
      ok_b_q     <= ok_b_d;
      rd_vld_q   <= rd_vld_d;
      rd_first_q <= rd_first_d;
      acc_q      <= acc_d;
      zero_q     <= zero_d;
      if (fin_fire) begin
        energy_q    <= e_new;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q  <= in_word_i.kind;
      which_q <= in_word_i.which_sequence;
      pos_q   <= in_word_i.position;
    end
    if (state_q == ST_ROT && cnt_q == '0) begin
      xp_q <= rdata_a;
    end
    if (fin_fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // sequence store
  fcae_ram #(
    .Width (1),
    .Depth (4 * MaxLen)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rdata_b)
  );

  // correlation chain
  logic             tap_o [MaxLen];
  logic             vld_o [MaxLen];
  logic [CorrW-1:0] corr_o [MaxLen];

  assign head = corr_o[0];

  for (genvar k = 0; k < MaxLen; k++) begin : g_cell
    logic             tap_in, vin;
    logic [CorrW-1:0] corr_in;
    if (k == 0) begin : g_first
      assign tap_in = rdata_a;
      assign vin    = rd_vld_q;
    end else begin : g_rest
      assign tap_in = tap_o[k-1];
      assign vin    = vld_o[k-1] && !rd_first_q;
    end
    if (k == MaxLen - 1) begin : g_last
      assign corr_in = head_new;
    end else begin : g_mid
      assign corr_in = corr_o[k+1];
    end
    fcae_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .x_i      (rdata_a),
      .sv_i     (rd_vld_q),
      .acc_ok_i (k != 0),
      .tap_i    (tap_in),
      .vin_i    (vin),
      .corr_i   (corr_in),
      .tap_o    (tap_o[k]),
      .vld_o    (vld_o[k]),
      .corr_o   (corr_o[k])
    );
  end

endmodule

FILE: sim/four_sequence_autocorr_energy_core_test.sv
// ----------------------------------------------------------------------------
// four_sequence_autocorr_energy_core_test
// Self-checking bench for the autocorrelation energy core. It fills the four
// sequence stores, then runs directed and random load, recompute and flip
// words under several length settings and idle patterns. A scoreboard
// predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module four_sequence_autocorr_energy_core_test;
  import fcae_pkg::*;

  localparam int StoreDepth = 256;
  localparam logic [1:0] KindUnused = 2'd3;
  localparam int WatchLimit = 60000;
  localparam int DrainCycles = 1400;

  // energy predictor and store of expected results
  class energy_predictor;
    bit           seq_bit[4*StoreDepth];
    int           corr[StoreDepth];
    longint       energy;
    int unsigned  len_first, len_second;
    out_word_t    pending_results[$];
    int           mismatches;
    int           checked;

    function new();
      foreach (corr[k]) corr[k] = 0;
      foreach (seq_bit[k]) seq_bit[k] = 0;
      energy = 0;
      len_first = LenFirstRst;
      len_second = LenSecondRst;
      mismatches = 0;
      checked = 0;
    endfunction

    function void set_length(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      if (idx == CfgLenFirst) len_first = val;
      else len_second = val;
    endfunction

    function int unsigned eff_len(int j);
      int unsigned r;
      r = (j < 2) ? len_first : len_second;
      return (r > StoreDepth) ? StoreDepth : r;
    endfunction

    function int elem(int j, int p);
      return seq_bit[j*StoreDepth + p] ? 1 : -1;
    endfunction

    function int unsigned span();
      return (eff_len(0) > eff_len(2)) ? eff_len(0) : eff_len(2);
    endfunction

    function int sat_corr(int c);
      if (c > 2047) return 2047;
      if (c < -2048) return -2048;
      return c;
    endfunction

    function longint sat_energy(longint e);
      if (e < 0) return 0;
      if (e > longint'(EnergyCap)) return longint'(EnergyCap);
      return e;
    endfunction

    function bit zero_flag();
      for (int s = 1; s < span(); s++) if (corr[s] != 0) return 0;
      return 1;
    endfunction

    // work out the result, if any, of an accepted input word
    function void note_word(in_word_t w);
      out_word_t exp_w;
      longint    e, prev, de;
      int        c, xp, dc, nc, lj, lw;
      int        p;
      p = w.position;
      case (w.kind)
        KIND_LOAD: begin
          seq_bit[w.which_sequence*StoreDepth + p] = w.element_value;
        end
        KIND_CALC: begin
          e = 0;
          corr[0] = 0;
          for (int s = 1; s < StoreDepth; s++) begin
            c = 0;
            for (int j = 0; j < 4; j++) begin
              lj = eff_len(j);
              for (int i = 0; i + s < lj; i++) c += elem(j, i) * elem(j, i + s);
            end
            c = sat_corr(c);
            corr[s] = c;
            e += longint'(c) * c;
          end
          energy = sat_energy(e);
          exp_w.energy = energy[28:0];
          exp_w.energy_change = '0;
          exp_w.all_zero = zero_flag();
          pending_results.push_back(exp_w);
        end
        KIND_FLIP: begin
          prev = energy;
          lj = eff_len(w.which_sequence);
          lw = span();
          if (p < lj) begin
            xp = elem(w.which_sequence, p);
            de = 0;
            for (int s = 1; s < lw; s++) begin
              dc = 0;
              if (p + s < lj) dc += xp * elem(w.which_sequence, p + s);
              if (p >= s) dc += elem(w.which_sequence, p - s) * xp;
              dc *= -2;
              nc = sat_corr(corr[s] + dc);
              de += longint'(nc) * nc - longint'(corr[s]) * corr[s];
              corr[s] = nc;
            end
            energy = sat_energy(energy + de);
          end
          seq_bit[w.which_sequence*StoreDepth + p] ^= 1'b1;
          exp_w.energy = energy[28:0];
          exp_w.energy_change = 30'(energy - prev);
          exp_w.all_zero = zero_flag();
          pending_results.push_back(exp_w);
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_word_t got);
      out_word_t exp_w;
      bit        bad;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
        return;
      end
      exp_w = pending_results.pop_front();
      checked++;
      bad = (got.energy !== exp_w.energy) || (got.energy_change !== exp_w.energy_change)
            || (got.all_zero !== exp_w.all_zero);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: energy exp %0d got %0d, change exp %0d got %0d, zero exp %b got %b",
                   checked, exp_w.energy, got.energy, exp_w.energy_change,
                   got.energy_change, exp_w.all_zero, got.all_zero);
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  in_word_t            in_word_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_word_t           out_word_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  energy_predictor energy_sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int idle_run = 0;
  int n_load = 0, n_calc = 0, n_flip = 0, n_cfg = 0;

  four_sequence_autocorr_energy_core dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // result side: check and pick the next ready
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) energy_sb.check_result(out_word_o);
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog on cycles with no word moving
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_run <= 0;
    else idle_run <= idle_run + 1;
    if (idle_run >= WatchLimit) begin
      $display("timeout with %0d results outstanding", energy_sb.pending_results.size());
      $display("four_sequence_autocorr_energy_core_test: FAIL");
      $finish;
    end
  end

  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    energy_sb.note_word(w);
    case (w.kind)
      KIND_LOAD: n_load++;
      KIND_CALC: n_calc++;
      KIND_FLIP: n_flip++;
      default: ;
    endcase
  endtask

  task automatic send_fields(logic [1:0] kind, int which, int pos, bit val);
    in_word_t w;
    w.kind = kind;
    w.which_sequence = which[1:0];
    w.position = pos[7:0];
    w.element_value = val;
    send_word(w);
  endtask

  // wait for every result, then let any trailing load finish
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (energy_sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_lengths(int first, int second);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgLenFirst;
    cfg_wdata_i <= first[CfgDataW-1:0];
    @(posedge clk_i);
    energy_sb.set_length(CfgLenFirst, first[CfgDataW-1:0]);
    cfg_idx_i <= CfgLenSecond;
    cfg_wdata_i <= second[CfgDataW-1:0];
    @(posedge clk_i);
    energy_sb.set_length(CfgLenSecond, second[CfgDataW-1:0]);
    cfg_we_i <= 1'b0;
    n_cfg++;
  endtask

  function automatic int pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 6) return $urandom_range(1);
    if (r < 10) return StoreDepth;
    if (r < 13) return $urandom_range(511, 257);
    if (r < 18) return $urandom_range(255, 64);
    return $urandom_range(40, 2);
  endfunction

  // one random word, mostly inside the current lengths
  task automatic send_random();
    int r, which, lim;
    r = $urandom_range(99);
    which = $urandom_range(3);
    lim = energy_sb.eff_len(which);
    if (lim < 1) lim = 1;
    if (r < 3) begin
      send_fields(KindUnused, which, $urandom_range(255), $urandom_range(1));
    end else if (r < 40) begin
      send_fields(KIND_LOAD, which, ($urandom_range(9) < 8) ? $urandom_range(lim - 1)
                  : $urandom_range(255), $urandom_range(1));
    end else if (r < 52) begin
      send_fields(KIND_CALC, which, $urandom_range(255), $urandom_range(1));
    end else begin
      send_fields(KIND_FLIP, which, ($urandom_range(9) < 8) ? $urandom_range(lim - 1)
                  : $urandom_range(255), $urandom_range(1));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill every element of every sequence so no unwritten entry is read
    set_lengths(StoreDepth, StoreDepth);
    send_idle_pct = 6;
    recv_idle_pct = 57;
    for (int j = 0; j < 4; j++)
      for (int p = 0; p < StoreDepth; p++) send_fields(KIND_LOAD, j, p, $urandom_range(1));

    // directed: full lengths, edge positions, all sequences, unused kind
    send_fields(KIND_CALC, 0, 0, 0);
    send_fields(KIND_FLIP, 0, 0, 0);
    send_fields(KIND_FLIP, 1, 255, 1);
    send_fields(KIND_FLIP, 2, 128, 0);
    send_fields(KIND_FLIP, 3, 255, 0);
    send_fields(KindUnused, 3, 255, 1);
    send_fields(KIND_LOAD, 3, 255, 1);
    send_fields(KIND_LOAD, 0, 0, 0);
    send_fields(KIND_CALC, 3, 255, 1);
    // lengths of two, flip beyond length, stale correlations
    set_lengths(2, 2);
    send_fields(KIND_FLIP, 1, 1, 0);
    send_fields(KIND_FLIP, 2, 200, 0);
    send_fields(KIND_CALC, 0, 0, 0);
    send_fields(KIND_FLIP, 0, 0, 0);
    // lengths that add no shift
    set_lengths(0, 1);
    send_fields(KIND_CALC, 0, 0, 0);
    send_fields(KIND_FLIP, 2, 0, 0);
    // lengths past the store depth
    set_lengths(511, 300);
    send_fields(KIND_CALC, 0, 0, 0);
    send_fields(KIND_FLIP, 3, 255, 0);
    // uneven pair lengths
    set_lengths(3, 17);
    send_fields(KIND_FLIP, 3, 16, 0);
    send_fields(KIND_CALC, 0, 0, 0);

    // random phases under three idle patterns
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 57 : 0;
      recv_idle_pct = (ph == 0) ? 57 : (ph == 1) ? 6 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        set_lengths(pick_length(), pick_length());
        for (int k = 0; k < 76; k++) begin
          send_random();
          if (seg == 1 && k == 40) begin
            in_valid_i <= 1'b0;
            @(posedge clk_i);
            while (energy_sb.pending_results.size() != 0) @(posedge clk_i);
          end
        end
      end
    end

    drain();
    $display("covered %0d loads, %0d recomputes, %0d flips over %0d length settings",
             n_load, n_calc, n_flip, n_cfg);
    $display("%0d results checked, %0d mismatches", energy_sb.checked, energy_sb.mismatches);
    if (energy_sb.mismatches == 0 && energy_sb.pending_results.size() == 0)
      $display("four_sequence_autocorr_energy_core_test: PASS");
    else
      $display("four_sequence_autocorr_energy_core_test: FAIL");
    $finish;
  end

endmodule
